// ----- rtl/dlfd_pkg.sv -----
`timescale 1ns / 1ps

package dlfd_pkg;

    // default header geometry
    localparam int DEF_KEY_DIGITS   = 4;
    localparam int DEF_VALUE_DIGITS = 4;

    // field widths
    localparam int BYTE_W   = 8;
    localparam int OPCODE_W = 4;
    localparam int LEN_W    = 14;
    localparam int POS_W    = 15;
    localparam int CNT_W    = 3;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;
    localparam int TDATA_W  = 48;

    localparam logic [LEN_W-1:0]  LEN_MAX    = 14'd9999;
    localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;
    localparam logic [BYTE_W-1:0] ASCII_NINE = 8'h39;

    typedef enum logic [2:0] {
        PH_OPCODE,
        PH_KEYLEN,
        PH_VALLEN,
        PH_PAYLOAD,
        PH_TRAIL,
        PH_ERROR
    } t_phase;

    typedef enum logic [KIND_W-1:0] {
        KIND_NONE,
        KIND_KEY,
        KIND_VALUE
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_SHORT,
        ST_NONDIGIT,
        ST_TRUNC
    } t_status;

    // one result word as it leaves the decode step
    typedef struct packed {
        t_kind                kind;
        logic [BYTE_W-1:0]    payload_byte;
        logic [OPCODE_W-1:0]  opcode;
        logic [LEN_W-1:0]     key_size;
        logic [LEN_W-1:0]     value_size;
        logic                 header_done;
        logic                 frame_last;
        t_status              status;
    } t_result;

endpackage

// ----- rtl/dlfd_in_stage.sv -----
`timescale 1ns / 1ps

module dlfd_in_stage (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [dlfd_pkg::BYTE_W-1:0] s_axis_tdata,
    input  logic                        s_axis_tlast,
    input  logic                        i_down_ready,
    output logic                        o_valid,
    output logic [dlfd_pkg::BYTE_W-1:0] o_byte,
    output logic                        o_last
);
    import dlfd_pkg::*;

    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              r_last;

    // free when empty or when the held word moves on this cycle
    assign s_axis_tready = !r_valid || i_down_ready;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_valid <= s_axis_tvalid;
        end
    end

    // input word register
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_byte <= s_axis_tdata;
            r_last <= s_axis_tlast;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_last  = r_last;

endmodule

// ----- rtl/dlfd_core.sv -----
`timescale 1ns / 1ps

module dlfd_core #(
    parameter int KEY_DIGITS   = dlfd_pkg::DEF_KEY_DIGITS,
    parameter int VALUE_DIGITS = dlfd_pkg::DEF_VALUE_DIGITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_fire,
    input  logic [dlfd_pkg::BYTE_W-1:0] i_byte,
    input  logic                        i_last,
    output dlfd_pkg::t_result           o_result
);
    import dlfd_pkg::*;

    localparam logic [CNT_W-1:0] KEY_CNT_END = CNT_W'(KEY_DIGITS - 1);
    localparam logic [CNT_W-1:0] VAL_CNT_END = CNT_W'(VALUE_DIGITS - 1);

    t_phase              r_phase,  n_phase;
    logic [CNT_W-1:0]    r_cnt,    n_cnt;
    logic [OPCODE_W-1:0] r_opcode, n_opcode;
    logic [LEN_W-1:0]    r_key,    n_key;
    logic [LEN_W-1:0]    r_val,    n_val;
    logic [POS_W-1:0]    r_pos,    n_pos;
    t_status             r_err,    n_err;

    logic                is_digit;
    logic [BYTE_W-1:0]   digit_diff;
    logic [3:0]          digit_val;
    logic                bad;
    logic [POS_W-1:0]    pos_inc;
    logic [POS_W-1:0]    total;
    logic [POS_W-1:0]    next_total;

    // length = length * 10 + digit, held at the largest legal length
    function automatic logic [LEN_W-1:0] add_digit(input logic [LEN_W-1:0] acc,
                                                   input logic [3:0] d);
        logic [LEN_W+2:0] v;
        v = ({3'b000, acc} << 3) + ({3'b000, acc} << 1) + {{(LEN_W-1){1'b0}}, d};
        return (v > {3'b000, LEN_MAX}) ? LEN_MAX : v[LEN_W-1:0];
    endfunction

    // digit decode
    assign is_digit   = (i_byte >= ASCII_ZERO) && (i_byte <= ASCII_NINE);
    assign digit_diff = i_byte - ASCII_ZERO;
    assign digit_val  = digit_diff[3:0];
    assign bad        = !is_digit && (r_phase == PH_OPCODE || r_phase == PH_KEYLEN
                                      || r_phase == PH_VALLEN);
    assign pos_inc    = r_pos + 1'b1;
    assign total      = {1'b0, r_key} + {1'b0, r_val};
    assign next_total = {1'b0, n_key} + {1'b0, n_val};

    // next state
    always_comb begin
        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_opcode = r_opcode;
        n_key    = r_key;
        n_val    = r_val;
        n_pos    = r_pos;
        n_err    = r_err;
        case (r_phase)
            PH_OPCODE: begin
                if (is_digit) begin
                    n_opcode = digit_val;
                    n_cnt    = '0;
                    n_phase  = PH_KEYLEN;
                end
            end
            PH_KEYLEN: begin
                if (is_digit) begin
                    n_key = add_digit(r_key, digit_val);
                    n_cnt = r_cnt + 1'b1;
                    if (r_cnt == KEY_CNT_END) begin
                        n_cnt   = '0;
                        n_phase = PH_VALLEN;
                    end
                end
            end
            PH_VALLEN: begin
                if (is_digit) begin
                    n_val = add_digit(r_val, digit_val);
                    n_cnt = r_cnt + 1'b1;
                    if (r_cnt == VAL_CNT_END) begin
                        n_cnt   = '0;
                        n_pos   = '0;
                        n_phase = (next_total == '0) ? PH_TRAIL : PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                n_pos = pos_inc;
                if (pos_inc >= total) begin
                    n_phase = PH_TRAIL;
                end
            end
            default: begin
            end
        endcase
        if (bad) begin
            n_err   = ST_NONDIGIT;
            n_phase = PH_ERROR;
        end
    end

    // result word
    always_comb begin
        o_result              = '0;
        o_result.opcode       = n_opcode;
        o_result.key_size     = n_key;
        o_result.value_size   = n_val;
        o_result.header_done  = (n_phase == PH_PAYLOAD) || (n_phase == PH_TRAIL);
        o_result.frame_last   = (r_phase == PH_VALLEN || r_phase == PH_PAYLOAD)
                                && (n_phase == PH_TRAIL);
        o_result.status       = ST_OK;
        if (r_phase == PH_PAYLOAD) begin
            o_result.kind         = ({1'b0, r_key} > r_pos) ? KIND_KEY : KIND_VALUE;
            o_result.payload_byte = i_byte;
        end else begin
            o_result.kind = KIND_NONE;
        end
        if (r_phase == PH_ERROR) begin
            o_result.status = r_err;
        end
        if (bad) begin
            o_result.status = ST_NONDIGIT;
        end
        if (i_last && o_result.status == ST_OK) begin
            if (n_phase == PH_OPCODE || n_phase == PH_KEYLEN || n_phase == PH_VALLEN) begin
                o_result.status = ST_SHORT;
            end else if (n_phase == PH_PAYLOAD) begin
                o_result.status = ST_TRUNC;
            end
        end
    end

    // frame state, back to the start after the last byte of a message
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_OPCODE;
            r_cnt    <= '0;
            r_opcode <= '0;
            r_key    <= '0;
            r_val    <= '0;
            r_pos    <= '0;
            r_err    <= ST_OK;
        end else if (i_fire) begin
            if (i_last) begin
                r_phase  <= PH_OPCODE;
                r_cnt    <= '0;
                r_opcode <= '0;
                r_key    <= '0;
                r_val    <= '0;
                r_pos    <= '0;
                r_err    <= ST_OK;
            end else begin
                r_phase  <= n_phase;
                r_cnt    <= n_cnt;
                r_opcode <= n_opcode;
                r_key    <= n_key;
                r_val    <= n_val;
                r_pos    <= n_pos;
                r_err    <= n_err;
            end
        end
    end

endmodule

// ----- rtl/dlfd_out_stage.sv -----
`timescale 1ns / 1ps

module dlfd_out_stage (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  dlfd_pkg::t_result             i_result,
    output logic                          o_ready,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [dlfd_pkg::TDATA_W-1:0]  m_axis_tdata,
    output logic [dlfd_pkg::KIND_W-1:0]   m_axis_tuser,
    output logic                          m_axis_tlast
);
    import dlfd_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_ready = !r_valid || m_axis_tready;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // result word register
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_result <= i_result;
        end
    end

    // pack the result word onto the stream
    assign m_axis_tvalid = r_valid;
    assign m_axis_tuser  = r_result.kind;
    assign m_axis_tlast  = r_result.frame_last;
    assign m_axis_tdata  = {5'b00000,
                            r_result.status,
                            r_result.header_done,
                            r_result.value_size,
                            r_result.key_size,
                            r_result.opcode,
                            r_result.payload_byte};

endmodule

// ----- rtl/decimal_length_frame_decoder.sv -----
`timescale 1ns / 1ps

// Decodes messages of the form: one ASCII opcode digit, KEY_DIGITS decimal digits of
// key length, VALUE_DIGITS decimal digits of value length (most significant first),
// then the key and value bytes. Every byte taken in gives exactly one result word:
// payload bytes are tagged key or value in tuser, the byte that completes the
// payload (or the last header digit when both lengths are zero) carries tlast, and
// each word shows the opcode and lengths decoded so far with a status code. tlast on
// the input closes a message and returns the decoder to its start state. Lengths
// above 9999 are held at 9999. The block takes one byte per clock while the output is
// not stalled; each byte passes the input word register, a single pass of the decode
// step and the result register before its result word is offered, with both sides
// free to stall independently.
module decimal_length_frame_decoder #(
    parameter int KEY_DIGITS   = dlfd_pkg::DEF_KEY_DIGITS,
    parameter int VALUE_DIGITS = dlfd_pkg::DEF_VALUE_DIGITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [7:0] data_byte
    input  logic [dlfd_pkg::BYTE_W-1:0]   s_axis_tdata,
    input  logic                          s_axis_tlast,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [7:0] payload_byte, [11:8] opcode, [25:12] key size, [39:26] value size,
    // [40] header_done, [42:41] status, [47:43] zero
    output logic [dlfd_pkg::TDATA_W-1:0]  m_axis_tdata,
    // [1:0] kind
    output logic [dlfd_pkg::KIND_W-1:0]   m_axis_tuser,
    output logic                          m_axis_tlast
);
    import dlfd_pkg::*;

    logic              in_valid;
    logic [BYTE_W-1:0] in_byte;
    logic              in_last;
    logic              out_ready;
    logic              step_fire;
    t_result           step_result;

    assign step_fire = in_valid && out_ready;

    // input word register
    dlfd_in_stage u_in_stage (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .i_down_ready  (out_ready),
        .o_valid       (in_valid),
        .o_byte        (in_byte),
        .o_last        (in_last)
    );

    // decode step and frame state
    dlfd_core #(
        .KEY_DIGITS   (KEY_DIGITS),
        .VALUE_DIGITS (VALUE_DIGITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (step_fire),
        .i_byte   (in_byte),
        .i_last   (in_last),
        .o_result (step_result)
    );

    // result register
    dlfd_out_stage u_out_stage (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (in_valid),
        .i_result      (step_result),
        .o_ready       (out_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // payload words only once the header is complete
    a_payload_after_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != KIND_NONE |-> m_axis_tdata[40])
        else $error("payload word without a complete header");

    // the frame end is only marked with a complete header
    a_last_after_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[40])
        else $error("frame end without a complete header");

    // a header error never passes payload or a complete header
    a_error_blocks_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[42:41] == ST_NONDIGIT
        |-> m_axis_tuser == KIND_NONE && !m_axis_tdata[40] && !m_axis_tlast)
        else $error("payload or header flag alongside a header error");

    // a result word leaves only if a byte reached the decode step
    a_result_from_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(step_fire))
        else $error("result word without a decoded byte");

endmodule
